FILE: design/icmp_er_pkg.sv
package icmp_er_pkg;

    // message length counter width, also the width of the msg_length field
    localparam int LEN_W           = 10;
    localparam int MAX_MSG_LEN_DEF = 576;
    localparam int MIN_MSG_LEN     = 8;

    // ICMP type code of an echo request
    localparam logic [7:0] ICMP_TYPE_ECHO_REQUEST = 8'd8;

    // fully folded ones-complement sum of a valid message
    localparam logic [15:0] SUM_ALL_ONES = 16'hFFFF;

    // one reply byte with its end-of-message verdicts
    typedef struct packed {
        logic [LEN_W-1:0] msg_length;
        logic             accept;
        logic             length_ok;
        logic             echo_request;
        logic             checksum_ok;
        logic             reply_last;
        logic [7:0]       reply_byte;
    } t_result;

    // 16-bit ones-complement add with end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

FILE: design/icmp_echo_reply_stream.sv
// Channel   Dir  Handshake              Payload
// request   in   i_s_tvalid/o_s_tready  i_s_tdata = msg_byte, i_s_tlast = last_byte
// reply     out  o_m_tvalid/i_m_tready  o_m_tdata = byte + verdicts, o_m_tlast = reply_last
//
// One request byte is taken per cycle; its reply bytes are written to a
// four-entry output queue at the same edge and leave one per cycle while i_m_tready is high.
// The checksum high byte gives no reply and the low byte gives two, so the
// sustained rate is one byte per cycle; o_s_tready drops when three or more
// reply bytes are queued. Reset (synchronous, active low) empties the queue
// and clears the message state; the state also clears after every last byte.
module icmp_echo_reply_stream #(
    parameter int MAX_MSG_LEN = icmp_er_pkg::MAX_MSG_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] msg_byte
    input  logic        i_s_tlast,   // last_byte
    // reply side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [7:0] reply_byte, [8] checksum_ok, [9] echo_request, [10] length_ok,
    // [11] accept, [21:12] msg_length, [23:22] zero
    output logic [23:0] o_m_tdata,
    output logic        o_m_tlast    // reply_last
);
    import icmp_er_pkg::*;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_MSG_LEN);
    localparam logic [LEN_W-1:0] MIN_LEN = LEN_W'(MIN_MSG_LEN);

    // message state
    logic [LEN_W-1:0] r_byte_count, n_byte_count;
    logic [15:0]      r_running_sum, n_running_sum;
    logic [7:0]       r_pending_high_byte, n_pending_high_byte;
    logic [15:0]      r_first_word, n_first_word;
    logic [7:0]       r_held_checksum_byte, n_held_checksum_byte;
    logic             r_odd_phase, n_odd_phase;
    logic             r_too_long, n_too_long;

    // reply queue
    t_result     r_q [0:3];
    logic [1:0]  r_rd, r_wr;
    logic [2:0]  r_cnt;
    logic [1:0]  wr_nxt;
    logic [1:0]  n_push;
    t_result     n_e0, n_e1;

    logic        s_fire, m_fire;
    logic [7:0]  b;
    logic [15:0] old_ck, new_ck;
    t_result     verdict;

    assign o_s_tready = (r_cnt <= 3'd2);
    assign o_m_tvalid = (r_cnt != 3'd0);
    assign s_fire     = i_s_tvalid && o_s_tready;
    assign m_fire     = o_m_tvalid && i_m_tready;
    assign b          = i_s_tdata;
    assign wr_nxt     = r_wr + 2'd1;

    // queue head onto the reply port
    assign o_m_tdata = {2'b00, r_q[r_rd].msg_length, r_q[r_rd].accept, r_q[r_rd].length_ok,
                        r_q[r_rd].echo_request, r_q[r_rd].checksum_ok, r_q[r_rd].reply_byte};
    assign o_m_tlast = r_q[r_rd].reply_last;

    // checksum update for the type/code word turning into zero
    assign old_ck = {r_held_checksum_byte, b};
    assign new_ck = ~oc_add(~old_ck, ~r_first_word);

    // next message state, verdicts and reply entries
    always_comb begin
        n_running_sum        = r_running_sum;
        n_pending_high_byte  = r_pending_high_byte;
        n_first_word         = r_first_word;
        n_held_checksum_byte = r_held_checksum_byte;
        n_odd_phase          = ~r_odd_phase;
        n_too_long           = r_too_long || (r_byte_count >= MAX_LEN);
        n_byte_count         = r_byte_count;
        n_push               = 2'd1;
        n_e0                 = '0;
        n_e1                 = '0;
        verdict              = '0;

        // running sum over big-endian words
        if (!r_odd_phase) begin
            if (i_s_tlast) begin
                n_running_sum = oc_add(r_running_sum, {b, 8'h00});
            end else begin
                n_pending_high_byte = b;
            end
        end else begin
            n_running_sum = oc_add(r_running_sum, {r_pending_high_byte, b});
        end

        // saturating length
        if (r_byte_count <= MAX_LEN && r_byte_count != '1) begin
            n_byte_count = r_byte_count + LEN_W'(1);
        end

        // reply bytes by position
        unique case (r_byte_count)
            LEN_W'(0): begin
                n_first_word = {b, 8'h00};
            end
            LEN_W'(1): begin
                n_first_word = {r_first_word[15:8], b};
            end
            LEN_W'(2): begin
                n_held_checksum_byte = b;
                n_e0.reply_byte      = b;
                n_push               = i_s_tlast ? 2'd1 : 2'd0;
            end
            LEN_W'(3): begin
                n_e0.reply_byte = new_ck[15:8];
                n_e1.reply_byte = new_ck[7:0];
                n_push          = 2'd2;
            end
            default: begin
                n_e0.reply_byte = b;
            end
        endcase

        // verdicts on the final reply byte
        verdict.reply_last   = 1'b1;
        verdict.checksum_ok  = (n_running_sum == SUM_ALL_ONES);
        verdict.echo_request = (n_first_word[15:8] == ICMP_TYPE_ECHO_REQUEST);
        verdict.length_ok    = !n_too_long && (n_byte_count >= MIN_LEN);
        verdict.accept       = verdict.checksum_ok && verdict.echo_request && verdict.length_ok;
        verdict.msg_length   = n_byte_count;
        if (i_s_tlast) begin
            if (n_push == 2'd2) begin
                n_e1 = {verdict[$bits(t_result)-1:8], n_e1.reply_byte};
            end else begin
                n_e0 = {verdict[$bits(t_result)-1:8], n_e0.reply_byte};
            end
        end
    end

    // message state registers, cleared after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count         <= '0;
            r_running_sum        <= '0;
            r_pending_high_byte  <= '0;
            r_first_word         <= '0;
            r_held_checksum_byte <= '0;
            r_odd_phase          <= 1'b0;
            r_too_long           <= 1'b0;
        end else if (s_fire) begin
            if (i_s_tlast) begin
                r_byte_count         <= '0;
                r_running_sum        <= '0;
                r_pending_high_byte  <= '0;
                r_first_word         <= '0;
                r_held_checksum_byte <= '0;
                r_odd_phase          <= 1'b0;
                r_too_long           <= 1'b0;
            end else begin
                r_byte_count         <= n_byte_count;
                r_running_sum        <= n_running_sum;
                r_pending_high_byte  <= n_pending_high_byte;
                r_first_word         <= n_first_word;
                r_held_checksum_byte <= n_held_checksum_byte;
                r_odd_phase          <= n_odd_phase;
                r_too_long           <= n_too_long;
            end
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (s_fire && n_push != 2'd0) begin
            r_q[r_wr] <= n_e0;
        end
        if (s_fire && n_push == 2'd2) begin
            r_q[wr_nxt] <= n_e1;
        end
    end

    // queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            if (m_fire) begin
                r_rd <= r_rd + 2'd1;
            end
            if (s_fire) begin
                r_wr <= r_wr + n_push;
            end
            r_cnt <= r_cnt + (s_fire ? {1'b0, n_push} : 3'd0) - {2'b00, m_fire};
        end
    end

`ifndef SYNTHESIS
    // queue never holds more than four entries
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4)
        else $error("reply queue overflow");

    // the last request byte leaves the message state cleared
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && i_s_tlast) |=> (r_byte_count == '0 && !r_odd_phase && !r_too_long))
        else $error("message state not cleared after last byte");

    // verdicts only travel with the final reply byte
    a_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tlast) |-> (o_m_tdata[21:8] == '0))
        else $error("verdict on a non-final reply byte");

    // reported length never above the saturation value
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast)
        |-> ({1'b0, o_m_tdata[21:12]} <= {1'b0, MAX_LEN} + 11'd1))
        else $error("message length above saturation");

    // the held checksum byte gives no reply unless it ends the message
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && r_byte_count == LEN_W'(2) && !i_s_tlast && !m_fire)
        |=> $stable(r_cnt))
        else $error("reply emitted for held checksum byte");
`endif

endmodule
